FILE: hdl/lps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants of the latency statistics block
// Field widths, record layout, report codes and the record update function.
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int FRONT_W  = 4;
   localparam int RTT_W    = 31;
   localparam int SEC_W    = 17;
   localparam int KIND_W   = 4;
   localparam int VALUE_W  = 48;
   localparam int CNT32_W  = 32;
   localparam int SUM_W    = 48;
   localparam int BIN_MAX  = 8;
   localparam int BIN_W    = 3;
   localparam int CUT_REGS = 7;
   localparam int EMIT_W   = 5;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   // Statistic codes of a report beat.
   localparam logic [KIND_W-1:0] KIND_COUNT = 4'd0;
   localparam logic [KIND_W-1:0] KIND_MIN   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_MAX   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_SUM   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_BIN0  = 4'd4;
   localparam int STAT_FIXED = 4;

   localparam logic [CUT_REGS-1:0][RTT_W-1:0] CUT_RESET = {
      31'd100000, 31'd50000, 31'd10000, 31'd5000, 31'd2000, 31'd1000, 31'd500
   };

   typedef enum logic [1:0] {ST_FETCH, ST_APPLY, ST_EMIT} state_type;

   typedef struct packed {
      logic [FRONT_W-1:0] front;
      logic [RTT_W-1:0]   rtt;
      logic [SEC_W-1:0]   second;
      logic [BIN_W-1:0]   bin;
   } item_type;

   typedef struct packed {
      logic [CNT32_W-1:0]              count;
      logic [RTT_W-1:0]                min;
      logic [RTT_W-1:0]                max;
      logic [SUM_W-1:0]                sum;
      logic [BIN_MAX-1:0][CNT32_W-1:0] bin_cnt;
   } rec_type;

   typedef struct packed {
      logic [SEC_W-1:0] second;
      rec_type          rec;
   } sec_row_type;

   // Add one sample to a record; a minimum of zero counts as unset.
   function automatic rec_type rec_add(input rec_type r, input logic [RTT_W-1:0] rtt,
                                       input logic [BIN_W-1:0] bin);
      rec_type n;
      n = r;
      if (r.min > rtt || r.min == '0) n.min = rtt;
      if (r.max < rtt) n.max = rtt;
      n.count = r.count + 32'd1;
      n.sum = r.sum + {{(SUM_W-RTT_W){1'b0}}, rtt};
      n.bin_cnt[bin] = r.bin_cnt[bin] + 32'd1;
      return n;
   endfunction

endpackage

FILE: hdl/lps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_req_if: sample channel
// Valid/ready channel carrying one latency sample per beat.
// ----------------------------------------------------------------------------
interface lps_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  front_id;
   logic [30:0] rtt_us;
   logic [16:0] second_of_day;

   modport source(output valid, output front_id, output rtt_us, output second_of_day,
                  input ready);
   modport sink(input valid, input front_id, input rtt_us, input second_of_day,
                output ready);
endinterface

FILE: hdl/lps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_rsp_if: report channel
// Valid/ready channel carrying one reported statistic per beat.
// ----------------------------------------------------------------------------
interface lps_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  out_front;
   logic [16:0] out_second;
   logic        scope;
   logic [3:0]  stat_kind;
   logic [47:0] stat_value;
   logic        last;

   modport source(output valid, output out_front, output out_second, output scope,
                  output stat_kind, output stat_value, output last, input ready);
   modport sink(input valid, input out_front, input out_second, input scope,
                input stat_kind, input stat_value, input last, output ready);
endinterface

FILE: hdl/lps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_queue: two-entry sample queue
// Decouples sample classification from the statistics engine.
// ----------------------------------------------------------------------------
module lps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lps_pkg::item_type din,
   output logic             full,
   input  logic             pop,
   output lps_pkg::item_type dout,
   output logic             not_empty
);
   import lps_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign dout      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= din;
   end
endmodule

FILE: hdl/lps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_front: sample intake and bin classification
// Drops samples for unknown fronts and picks the latency bin of the rest.
// ----------------------------------------------------------------------------
module lps_front #(
   parameter int FRONT_COUNT = 16,
   parameter int BIN_COUNT   = 8
) (
   lps_req_if.sink                                            req,
   input  logic [lps_pkg::CUT_REGS-1:0][lps_pkg::RTT_W-1:0]  cut_lines,
   input  logic                                               queue_full,
   output logic                                               push,
   output lps_pkg::item_type                                  item
);
   import lps_pkg::*;

   logic [BIN_W-1:0] bin;
   logic             in_range;

   // First bin whose cut line the sample does not exceed, else the last bin.
   always_comb begin
      bin = BIN_W'(BIN_COUNT - 1);
      for (int i = BIN_COUNT - 2; i >= 0; i--) begin
         if (i < CUT_REGS && req.rtt_us <= cut_lines[i]) bin = BIN_W'(i);
      end
   end

   assign in_range  = (32'(req.front_id) < 32'(FRONT_COUNT));
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full && in_range;

   always_comb begin
      item.front  = req.front_id;
      item.rtt    = req.rtt_us;
      item.second = req.second_of_day;
      item.bin    = bin;
   end
endmodule

FILE: hdl/lps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_back: statistics engine
// Read-modify-write of per-front records and serial rollover report.
// ----------------------------------------------------------------------------
module lps_back #(
   parameter int FRONT_COUNT = 16,
   parameter int BIN_COUNT   = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  lps_pkg::item_type q_item,
   input  logic              q_valid,
   output logic              q_pop,
   lps_rsp_if.source         rsp
);
   import lps_pkg::*;

   localparam int FIDX_W   = (FRONT_COUNT > 1) ? $clog2(FRONT_COUNT) : 1;
   localparam int HALF_LEN = STAT_FIXED + BIN_COUNT;
   localparam logic [EMIT_W-1:0] LAST_BEAT = EMIT_W'(2 * HALF_LEN - 1);

   state_type state_ff, state_in;
   item_type  item_ff;
   logic [FIDX_W-1:0]      idx_ff;
   logic [FRONT_COUNT-1:0] seen_ff;
   logic                   seen_rd_ff;

   sec_row_type sec_mem [FRONT_COUNT];
   rec_type     tot_mem [FRONT_COUNT];
   sec_row_type sec_rd_ff;
   rec_type     tot_rd_ff;

   rec_type            snap_sec_ff, snap_tot_ff;
   logic [SEC_W-1:0]   snap_second_ff;
   logic [FRONT_W-1:0] snap_front_ff;
   logic [EMIT_W-1:0]  beat_ff;

   logic               rsp_valid_ff;
   logic [FRONT_W-1:0] rsp_front_ff;
   logic [SEC_W-1:0]   rsp_second_ff;
   logic               rsp_scope_ff;
   logic [KIND_W-1:0]  rsp_kind_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic rd_en, wr_en, emit_en, slot_free, roll;
   logic [FIDX_W-1:0] rd_idx;
   sec_row_type sec_old, sec_new;
   rec_type     tot_new, base, emit_rec;
   logic               emit_scope;
   logic [EMIT_W-1:0]  emit_k;
   logic [KIND_W-1:0]  emit_kind;
   logic [VALUE_W-1:0] emit_value;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign rd_idx    = FIDX_W'(q_item.front);

   always_comb begin
      sec_old = seen_rd_ff ? sec_rd_ff : '0;
      roll    = seen_rd_ff && (sec_old.second != item_ff.second);
      base    = roll ? '0 : sec_old.rec;
      sec_new.second = item_ff.second;
      sec_new.rec    = rec_add(base, item_ff.rtt, item_ff.bin);
      tot_new        = rec_add(tot_rd_ff, item_ff.rtt, item_ff.bin);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FETCH: if (q_valid) state_in = ST_APPLY;
         ST_APPLY: state_in = roll ? ST_EMIT : ST_FETCH;
         ST_EMIT:  if (slot_free && beat_ff == LAST_BEAT) state_in = ST_FETCH;
         default:  state_in = ST_FETCH;
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop = 1'b0; rd_en = 1'b0; wr_en = 1'b0; emit_en = 1'b0;
      unique case (state_ff)
         ST_FETCH: begin q_pop = q_valid; rd_en = q_valid; end
         ST_APPLY: wr_en = 1'b1;
         ST_EMIT:  emit_en = slot_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
         seen_ff  <= '0;
         beat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) seen_ff[idx_ff] <= 1'b1;
         if (wr_en) beat_ff <= '0;
         else if (emit_en) beat_ff <= beat_ff + EMIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         item_ff    <= q_item;
         idx_ff     <= rd_idx;
         seen_rd_ff <= seen_ff[rd_idx];
         sec_rd_ff  <= sec_mem[rd_idx];
         tot_rd_ff  <= tot_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sec_mem[idx_ff] <= sec_new;
         tot_mem[idx_ff] <= seen_rd_ff ? tot_new : rec_add('0, item_ff.rtt, item_ff.bin);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && roll) begin
         snap_sec_ff    <= sec_old.rec;
         snap_tot_ff    <= tot_rd_ff;
         snap_second_ff <= sec_old.second;
         snap_front_ff  <= item_ff.front;
      end
   end

   always_comb begin
      emit_scope = (beat_ff >= EMIT_W'(HALF_LEN));
      emit_k     = emit_scope ? beat_ff - EMIT_W'(HALF_LEN) : beat_ff;
      emit_kind  = emit_k[KIND_W-1:0];
      emit_rec   = emit_scope ? snap_tot_ff : snap_sec_ff;
      case (emit_kind)
         KIND_COUNT: emit_value = VALUE_W'(emit_rec.count);
         KIND_MIN:   emit_value = VALUE_W'(emit_rec.min);
         KIND_MAX:   emit_value = VALUE_W'(emit_rec.max);
         KIND_SUM:   emit_value = emit_rec.sum;
         default:    emit_value = VALUE_W'(emit_rec.bin_cnt[BIN_W'(emit_kind - KIND_BIN0)]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (slot_free) rsp_valid_ff <= emit_en;
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         rsp_front_ff  <= snap_front_ff;
         rsp_second_ff <= snap_second_ff;
         rsp_scope_ff  <= emit_scope;
         rsp_kind_ff   <= emit_kind;
         rsp_value_ff  <= emit_value;
         rsp_last_ff   <= (beat_ff == LAST_BEAT);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_front  = rsp_front_ff;
   assign rsp.out_second = rsp_second_ff;
   assign rsp.scope      = rsp_scope_ff;
   assign rsp.stat_kind  = rsp_kind_ff;
   assign rsp.stat_value = rsp_value_ff;
   assign rsp.last       = rsp_last_ff;

   a_apply_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |-> $past(q_pop))
      else $error("record update without a dequeued sample");
   a_last_in_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_scope_ff)
      else $error("final report beat outside the totals scope");
   a_seen_after_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_APPLY |=> seen_ff[idx_ff])
      else $error("front not marked after its record was written");
endmodule

FILE: hdl/latency_per_second_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_per_second_stats: per-front round-trip-time statistics per second
// Keeps per-second and running count, min, max, sum and bins for each front
// and reports a front's closed second when a sample of a new second arrives.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat carries
//  req_bus   in         front_id, rtt_us, second_of_day (one sample)
//  rsp_bus   out        out_front, out_second, scope, stat_kind, stat_value, last
//  psel/...  in/out     APB-style write/read of cut lines 0..6 at 4*i
//
// A sample passes two engine states: ST_FETCH reads the front's records
// from the record memories, ST_APPLY updates and writes them back; the
// engine takes no new sample until this read-modify-write is done.
// A rollover adds 2*(4+BIN_COUNT) report beats, one per cycle while the
// report channel takes them; new samples wait in the two-entry queue.
// Synchronous active-high reset clears the seen flags, so every record reads
// as zero until first written, and restores the default cut lines.
// Either side may stall freely; the queue and output register decouple them.
// ----------------------------------------------------------------------------
module latency_per_second_stats #(
   parameter int FRONT_COUNT = 16,
   parameter int BIN_COUNT   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   lps_req_if.sink                       req_bus,
   lps_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lps_pkg::CSR_AW-1:0]    paddr,
   input  logic [lps_pkg::CSR_DW-1:0]    pwdata,
   output logic [lps_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);
   import lps_pkg::*;

   // Cut lines; user writes via the register port only while idle (unenforced).
   logic [CUT_REGS-1:0][RTT_W-1:0] cut_ff;
   logic [2:0] reg_idx;
   logic       wr_hit;

   // Front end to engine queue.
   logic     push, queue_full, q_valid, q_pop;
   item_type push_item, q_item;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_hit  = psel && penable && pwrite && (32'(reg_idx) < CUT_REGS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff <= CUT_RESET;
      end else if (wr_hit) begin
         cut_ff[reg_idx] <= pwdata[RTT_W-1:0];
      end
   end

   // Reads return the register in the low bits; unmapped addresses read zero.
   always_comb begin
      if (32'(reg_idx) < CUT_REGS) prdata = {1'b0, cut_ff[reg_idx]};
      else prdata = '0;
   end

   lps_front #(.FRONT_COUNT(FRONT_COUNT), .BIN_COUNT(BIN_COUNT)) u_front (
      .req        (req_bus),
      .cut_lines  (cut_ff),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   lps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .din       (push_item),
      .full      (queue_full),
      .pop       (q_pop),
      .dout      (q_item),
      .not_empty (q_valid)
   );

   lps_back #(.FRONT_COUNT(FRONT_COUNT), .BIN_COUNT(BIN_COUNT)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );
endmodule
